// File: sv/assert_macros.svh
// assertion helpers, clocked on i_clk, off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SDS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sds assertion failed");

// next-cycle implication
`define SDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sds assertion failed");

`endif

// File: sv/sds_pkg.sv
package sds_pkg;

    localparam int CYL_W       = 16;
    localparam int TOT_W       = CYL_W + 1;
    localparam int DISK_W      = 17;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int SDS_MAX_REQ = 32;

    localparam logic [DISK_W-1:0] DISK_LIM = DISK_W'(1) << CYL_W;
    localparam logic [CYL_W-1:0]  CYL_MAX  = {CYL_W{1'b1}};

    localparam logic [DISK_W-1:0] DISK_RST = DISK_LIM;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISK_CYLINDERS = 2'd0,
        CFG_START_HEAD     = 2'd1,
        CFG_SWEEP_UP       = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CYL_W-1:0] cylinder;
        logic             batch_end;
    } t_req;

    typedef struct packed {
        logic [CYL_W-1:0] from_cylinder;
        logic [CYL_W-1:0] to_cylinder;
        logic [CYL_W-1:0] seek_distance;
        logic [TOT_W-1:0] total_seek;
        logic             requests_dropped;
        logic             last;
    } t_res;

endpackage

// File: sv/scan_disk_scheduler_top.sv
// SCAN (elevator) disk scheduler. Requests load one per cycle while busy is low. The item
// with batch_end set closes the batch; busy then rises and the schedule is produced by a
// single compare unit that walks the request store entry by entry (a read state S_RD,
// then a compare state S_CMP), then picks the winner in S_PICK. Each served request and
// the end of each sweep costs one walk of the whole store (the disk-end move, if the head
// is not already there, is taken at the end of the first sweep). Results come out as
// one-cycle strobes on o_res_strobe and cannot be held off; the receiver must take every
// strobe. The first result is the zero move from the start head to itself, and the final
// one carries last.
`include "assert_macros.svh"

module scan_disk_scheduler_top
    import sds_pkg::*;
#(
    parameter int MAX_REQUESTS = SDS_MAX_REQ
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_req                  i_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_res_strobe,
    output t_res                  o_result
);

    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_REQUESTS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INIT = 5'b00010,
        S_RD   = 5'b00100,
        S_CMP  = 5'b01000,
        S_PICK = 5'b10000
    } t_state;

    t_state                  r_state;
    logic [CYL_W-1:0]        r_mem [MAX_REQUESTS];
    logic [CYL_W-1:0]        r_rd_data;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_idx;
    logic                    r_ovf;
    logic [DISK_W-1:0]       r_disk;
    logic [CYL_W-1:0]        r_head_cfg;
    logic                    r_up_cfg;
    logic                    r_up;
    logic [CYL_W-1:0]        r_maxp;
    logic [CYL_W-1:0]        r_start;
    logic [CYL_W-1:0]        r_pos;
    logic                    r_phase2;
    logic                    r_found;
    logic [CYL_W-1:0]        r_best;
    logic [IDX_W-1:0]        r_best_idx;
    logic [MAX_REQUESTS-1:0] r_served;
    t_res                    r_pend;
    t_res                    r_out;
    logic                    r_strobe;

    logic             w_accept;
    logic             w_full;
    logic [CYL_W-1:0] w_maxp;
    logic [CYL_W-1:0] w_head;
    logic [CYL_W-1:0] w_val;
    logic             w_cand;
    logic             w_small;
    logic             w_better;
    logic [CYL_W-1:0] w_end;
    logic [CYL_W-1:0] w_to;
    logic [CYL_W-1:0] w_dist;
    logic             w_emit;
    t_res             w_move;
    t_res             w_final;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_FULL);

    assign w_maxp = (r_disk == '0)      ? '0 :
                    (r_disk > DISK_LIM) ? CYL_MAX : CYL_W'(r_disk - DISK_W'(1));
    assign w_head = (r_head_cfg > w_maxp) ? w_maxp : r_head_cfg;

    assign w_val    = (r_rd_data > r_maxp) ? r_maxp : r_rd_data;
    assign w_cand   = !r_served[r_idx[IDX_W-1:0]] &&
                      (r_phase2 || (r_up ? (w_val >= r_start) : (w_val <= r_start)));
    assign w_small  = r_phase2 ? !r_up : r_up;
    assign w_better = !r_found || (w_small ? (w_val < r_best) : (w_val > r_best));

    assign w_end  = r_up ? r_maxp : '0;
    assign w_to   = r_found ? r_best : w_end;
    assign w_dist = (w_to >= r_pos) ? (w_to - r_pos) : (r_pos - w_to);
    assign w_emit = (r_state == S_PICK) && (r_found || r_phase2 || (r_pos != w_end));

    always_comb begin
        w_move.from_cylinder    = r_pos;
        w_move.to_cylinder      = w_to;
        w_move.seek_distance    = w_dist;
        w_move.total_seek       = r_pend.total_seek + TOT_W'(w_dist);
        w_move.requests_dropped = r_ovf;
        w_move.last             = 1'b0;
    end

    always_comb begin
        w_final      = r_pend;
        w_final.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_full) begin
            r_mem[r_count[IDX_W-1:0]] <= i_item.cylinder;
        end
        r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk     <= DISK_RST;
            r_head_cfg <= '0;
            r_up_cfg   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DISK_CYLINDERS: r_disk     <= i_cfg_data[DISK_W-1:0];
                CFG_START_HEAD:     r_head_cfg <= i_cfg_data[CYL_W-1:0];
                CFG_SWEEP_UP:       r_up_cfg   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_phase2 <= 1'b0;
            r_served <= '0;
        end else begin
            r_strobe <= w_emit;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (!w_full) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_item.batch_end) begin
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    r_maxp   <= w_maxp;
                    r_start  <= w_head;
                    r_pos    <= w_head;
                    r_up     <= r_up_cfg;
                    r_served <= '0;
                    r_phase2 <= 1'b0;
                    r_found  <= 1'b0;
                    r_idx    <= '0;
                    r_pend   <= '{from_cylinder: w_head, to_cylinder: w_head,
                                  seek_distance: '0, total_seek: '0,
                                  requests_dropped: r_ovf, last: 1'b0};
                    r_state  <= S_RD;
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_cand && w_better) begin
                        r_found    <= 1'b1;
                        r_best     <= w_val;
                        r_best_idx <= r_idx[IDX_W-1:0];
                    end
                    if (r_idx + CNT_W'(1) == r_count) begin
                        r_state <= S_PICK;
                    end else begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_PICK: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    if (r_found) begin
                        r_out                <= r_pend;
                        r_pend               <= w_move;
                        r_pos                <= w_to;
                        r_served[r_best_idx] <= 1'b1;
                        r_state              <= S_RD;
                    end else if (!r_phase2) begin
                        r_phase2 <= 1'b1;
                        r_state  <= S_RD;
                        if (r_pos != w_end) begin
                            r_out  <= r_pend;
                            r_pend <= w_move;
                            r_pos  <= w_to;
                        end
                    end else begin
                        r_out   <= w_final;
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_strobe = r_strobe;
    assign o_result     = r_out;

    `SDS_ASSERT_NEXT(a_load_counts, w_accept, r_count != '0)
    `SDS_ASSERT_NOW(a_last_ends_batch, o_res_strobe && o_result.last, !busy)
    `SDS_ASSERT_NEXT(a_finish_emits, (r_state == S_PICK) && !r_found && r_phase2,
                     o_res_strobe && o_result.last)
    `SDS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_FULL)

endmodule

// File: verif/tb_scan_disk_scheduler_top.sv
module tb_scan_disk_scheduler_top;
    import sds_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int ITEM_TARGET = 370;
    localparam int CYCLE_LIMIT = 800000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_req                  i_item = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_res_strobe;
    t_res                  o_result;

    scan_disk_scheduler_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_res_strobe (o_res_strobe),
        .o_result     (o_result)
    );

    logic [DISK_W-1:0] disk_cyl_m = DISK_RST;
    logic [CYL_W-1:0]  head_m = '0;
    logic              sweep_up_m = 1'b1;
    logic [CYL_W-1:0]  held_cyl [SDS_MAX_REQ];
    int                held_count = 0;
    logic              spill_seen = 1'b0;
    int unsigned       head_pos;
    int unsigned       seek_sum;
    t_res              batch_moves[$];
    t_res              expected_moves[$];

    t_req              pending_reqs[$];
    int                items_queued = 0;
    int                items_taken = 0;
    int                burst_left = 0;
    int                gap_left = 0;
    int                mismatch_count = 0;
    int                cycle_count = 0;
    t_res              want;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void add_move(int unsigned to);
        t_res        m;
        int unsigned move_len;
        move_len = (to >= head_pos) ? to - head_pos : head_pos - to;
        seek_sum += move_len;
        m.from_cylinder    = head_pos[CYL_W-1:0];
        m.to_cylinder      = to[CYL_W-1:0];
        m.seek_distance    = move_len[CYL_W-1:0];
        m.total_seek       = seek_sum[TOT_W-1:0];
        m.requests_dropped = spill_seen;
        m.last             = 1'b0;
        head_pos = to;
        batch_moves.push_back(m);
    endfunction

    function automatic void take_request(t_req r);
        int unsigned lim;
        int unsigned maxp;
        int unsigned hd;
        int unsigned v;
        int unsigned order [SDS_MAX_REQ];
        int          n;
        int          j;
        t_res        m;
        if (held_count < SDS_MAX_REQ) begin
            held_cyl[held_count] = r.cylinder;
            held_count++;
        end else begin
            spill_seen = 1'b1;
        end
        if (!r.batch_end) return;
        lim = 32'(disk_cyl_m);
        if (lim == 0) lim = 1;
        if (lim > DISK_LIM) lim = DISK_LIM;
        maxp = lim - 1;
        hd = (head_m > maxp) ? maxp : 32'(head_m);
        n = held_count;
        for (int i = 0; i < n; i++) begin
            v = (held_cyl[i] > maxp) ? maxp : 32'(held_cyl[i]);
            j = i;
            while (j > 0 && order[j-1] > v) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = v;
        end
        batch_moves.delete();
        seek_sum = 0;
        head_pos = hd;
        add_move(hd);
        if (sweep_up_m) begin
            for (int i = 0; i < n; i++)
                if (order[i] >= hd) add_move(order[i]);
            if (head_pos != maxp) add_move(maxp);
            for (int i = n - 1; i >= 0; i--)
                if (order[i] < hd) add_move(order[i]);
        end else begin
            for (int i = n - 1; i >= 0; i--)
                if (order[i] <= hd) add_move(order[i]);
            if (head_pos != 0) add_move(0);
            for (int i = 0; i < n; i++)
                if (order[i] > hd) add_move(order[i]);
        end
        for (int i = 0; i < batch_moves.size(); i++) begin
            m = batch_moves[i];
            m.last = (i == batch_moves.size() - 1);
            expected_moves.push_back(m);
        end
        held_count = 0;
        spill_seen = 1'b0;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < 40) $display("MISMATCH @%0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned exp_val);
        if (got != exp_val)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, exp_val));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_DISK_CYLINDERS: disk_cyl_m = val[DISK_W-1:0];
            CFG_START_HEAD:     head_m = val[CYL_W-1:0];
            CFG_SWEEP_UP:       sweep_up_m = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_req(int unsigned cyl, bit last_one);
        t_req r;
        r.cylinder  = cyl[CYL_W-1:0];
        r.batch_end = last_one;
        pending_reqs.push_back(r);
        items_queued++;
    endtask

    task automatic add_batch(int n);
        int unsigned lim;
        int unsigned maxp;
        int unsigned cyl;
        lim = 32'(disk_cyl_m);
        if (lim == 0) lim = 1;
        if (lim > DISK_LIM) lim = DISK_LIM;
        maxp = lim - 1;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                5:       cyl = 32'(head_m);
                6:       cyl = maxp;
                7:       cyl = maxp + $urandom_range(0, 3);
                8:       cyl = $urandom_range(0, 3);
                9:       cyl = $urandom_range(0, maxp);
                default: cyl = $urandom_range(0, 65535);
            endcase
            if (cyl > 65535) cyl = 65535;
            add_req(cyl, i == n - 1);
        end
    endtask

    task automatic wait_idle(int settle);
        while (!(items_taken == items_queued && expected_moves.size() == 0 && !busy))
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (start && !busy) begin
                take_request(i_item);
                items_taken++;
            end
            if (start && busy) begin
                // hold the item until the block frees up
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                i_item <= pending_reqs.pop_front();
                start <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) begin
            if (expected_moves.size() == 0) begin
                report_mismatch("result with no item pending");
            end else begin
                want = expected_moves.pop_front();
                check_field("from_cylinder", o_result.from_cylinder, want.from_cylinder);
                check_field("to_cylinder", o_result.to_cylinder, want.to_cylinder);
                check_field("seek_distance", o_result.seek_distance, want.seek_distance);
                check_field("total_seek", o_result.total_seek, want.total_seek);
                check_field("requests_dropped", o_result.requests_dropped,
                            want.requests_dropped);
                check_field("last", o_result.last, want.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stim
        logic [DISK_W-1:0] disk;
        int unsigned       lim;
        int unsigned       hd;
        int                n_batches;
        int                n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_req(65535, 1'b0);
        add_req(0, 1'b0);
        add_req(32768, 1'b1);
        add_req(0, 1'b1);
        wait_idle(8);

        write_reg(CFG_START_HEAD, 17'h0FFFF);
        write_reg(CFG_SWEEP_UP, 17'h0);
        add_req(0, 1'b0);
        add_req(65535, 1'b0);
        add_req(100, 1'b0);
        add_req(65535, 1'b1);
        wait_idle(8);

        write_reg(CFG_DISK_CYLINDERS, 17'd1);
        add_req(5, 1'b0);
        add_req(0, 1'b1);
        wait_idle(8);

        write_reg(CFG_DISK_CYLINDERS, 17'd0);
        add_req(7, 1'b1);
        wait_idle(8);

        write_reg(CFG_DISK_CYLINDERS, 17'h1FFFF);
        write_reg(CFG_SWEEP_UP, 17'h1);
        add_req(65535, 1'b0);
        add_req(1, 1'b1);
        wait_idle(8);

        write_reg(CFG_DISK_CYLINDERS, 17'd100);
        write_reg(CFG_START_HEAD, 17'd500);
        add_req(50, 1'b0);
        add_req(99, 1'b0);
        add_req(150, 1'b1);
        wait_idle(8);
        write_reg(CFG_SWEEP_UP, 17'h0);
        add_req(99, 1'b0);
        add_req(0, 1'b1);
        wait_idle(8);

        write_reg(CFG_IDX_SPARE, 17'h1FFFF);
        write_reg(CFG_DISK_CYLINDERS, DISK_LIM);
        write_reg(CFG_START_HEAD, 17'd40);
        write_reg(CFG_SWEEP_UP, 17'h1);
        add_req(40, 1'b0);
        add_req(40, 1'b0);
        add_req(10, 1'b0);
        add_req(70, 1'b1);
        wait_idle(8);
        write_reg(CFG_SWEEP_UP, 17'h0);
        add_req(40, 1'b0);
        add_req(90, 1'b1);
        wait_idle(8);

        while (items_queued < ITEM_TARGET) begin
            case ($urandom_range(0, 6))
                0:       disk = '0;
                1:       disk = 17'd1;
                2:       disk = DISK_W'($urandom_range(2, 300));
                3:       disk = DISK_LIM;
                4:       disk = DISK_W'($urandom_range(65537, 131071));
                default: disk = DISK_W'($urandom_range(1, 65536));
            endcase
            lim = (disk == 0) ? 1 : ((disk > DISK_LIM) ? 32'(DISK_LIM) : 32'(disk));
            case ($urandom_range(0, 4))
                0:       hd = 0;
                1:       hd = 65535;
                2:       hd = lim - 1;
                3:       hd = $urandom_range(0, lim - 1);
                default: hd = $urandom_range(0, 65535);
            endcase
            if ($urandom_range(0, 5) == 0) write_reg(CFG_IDX_SPARE, 17'($urandom));
            write_reg(CFG_DISK_CYLINDERS, disk);
            write_reg(CFG_START_HEAD, {1'($urandom_range(0, 1)), hd[CYL_W-1:0]});
            write_reg(CFG_SWEEP_UP, 17'($urandom));
            n_batches = $urandom_range(1, 5);
            for (int b = 0; b < n_batches; b++) begin
                case ($urandom_range(0, 19))
                    0:       n = $urandom_range(SDS_MAX_REQ + 1, SDS_MAX_REQ + 8);
                    1:       n = SDS_MAX_REQ;
                    2:       n = SDS_MAX_REQ - 1;
                    default: n = $urandom_range(1, 8);
                endcase
                add_batch(n);
            end
            wait_idle(8);
        end

        wait_idle(20);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
